// ----- rtl/atfp_pkg.sv -----
// Package for the AT frame parser: transfer payload structs, result kinds
// and configuration register indexes. No dependencies.
package atfp_pkg;

    localparam logic [7:0]  CHAR_A       = 8'h41;
    localparam logic [7:0]  CHAR_T       = 8'h54;
    localparam logic [15:0] SUM_SEED_RST = 16'hAB34;
    localparam logic [15:0] TIMEOUT_RST  = 16'd225;
    localparam logic [15:0] TICKS_MAX    = 16'hFFFF;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } t_in_kind;

    typedef enum logic [2:0] {
        RK_HEADER  = 3'd0,
        RK_DATA    = 3'd1,
        RK_GOOD    = 3'd2,
        RK_BAD     = 3'd3,
        RK_ABANDON = 3'd4
    } t_result_kind;

    typedef enum logic {
        CFG_SUM_SEED      = 1'b0,
        CFG_FRAME_TIMEOUT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [7:0]  command_code;
        logic [31:0] frame_length;
        logic [7:0]  data_value;
        logic [31:0] data_index;
        logic        last_data;
    } t_out_item;

endpackage

// ----- rtl/atfp_core.sv -----
// Frame state machine, checksum, length and timeout counters of the AT frame parser.
// Produces at most one result per accepted item. Depends on atfp_pkg.
module atfp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_take,
    input  atfp_pkg::t_in_item i_item,
    output logic               o_res_valid,
    output atfp_pkg::t_out_item o_res
);

    typedef enum logic [2:0] {
        PH_WAIT_A,
        PH_WAIT_T,
        PH_WAIT_CMD,
        PH_WAIT_LEN,
        PH_WAIT_DATA,
        PH_WAIT_SUMH,
        PH_WAIT_SUML
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_sum, n_sum;
    logic [31:0] r_len, n_len;
    logic [1:0]  r_len_cnt, n_len_cnt;
    logic [31:0] r_data_cnt, n_data_cnt;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_ticks, n_ticks;
    logic [15:0] r_sum_seed;
    logic [15:0] r_timeout;

    logic [7:0]  b;
    logic [31:0] data_cnt_inc;

    assign b            = i_item.byte_value;
    assign data_cnt_inc = r_data_cnt + 32'd1;

    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_len       = r_len;
        n_len_cnt   = r_len_cnt;
        n_data_cnt  = r_data_cnt;
        n_cmd       = r_cmd;
        n_ticks     = r_ticks;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_item.kind == atfp_pkg::KIND_TICK) begin
            if (r_phase != PH_WAIT_A) begin
                if (r_ticks != atfp_pkg::TICKS_MAX) begin
                    n_ticks = r_ticks + 16'd1;
                end
                if (n_ticks >= r_timeout) begin
                    n_phase     = PH_WAIT_A;
                    o_res_valid = 1'b1;
                    o_res.result_kind = atfp_pkg::RK_ABANDON;
                end
            end
        end else begin
            unique case (r_phase)
                PH_WAIT_A: begin
                    if (b == atfp_pkg::CHAR_A) begin
                        n_phase = PH_WAIT_T;
                        n_ticks = '0;
                    end
                end
                PH_WAIT_T: begin
                    if (b == atfp_pkg::CHAR_T) begin
                        n_phase    = PH_WAIT_CMD;
                        n_sum      = r_sum_seed;
                        n_len      = '0;
                        n_data_cnt = '0;
                        n_cmd      = '0;
                    end else begin
                        n_phase = PH_WAIT_A;
                    end
                end
                PH_WAIT_CMD: begin
                    n_cmd     = b;
                    n_sum     = r_sum + {8'd0, b};
                    n_len_cnt = '0;
                    n_phase   = PH_WAIT_LEN;
                end
                PH_WAIT_LEN: begin
                    n_sum     = r_sum + {8'd0, b};
                    n_len     = {r_len[23:0], b};
                    n_len_cnt = r_len_cnt + 2'd1;
                    if (r_len_cnt == 2'd3) begin
                        n_phase     = (n_len != '0) ? PH_WAIT_DATA : PH_WAIT_SUMH;
                        o_res_valid = 1'b1;
                        o_res.result_kind = atfp_pkg::RK_HEADER;
                    end
                end
                PH_WAIT_DATA: begin
                    n_sum      = r_sum + {8'd0, b};
                    n_data_cnt = data_cnt_inc;
                    if (data_cnt_inc == r_len) begin
                        n_phase = PH_WAIT_SUMH;
                    end
                    o_res_valid      = 1'b1;
                    o_res.result_kind = atfp_pkg::RK_DATA;
                    o_res.data_value = b;
                    o_res.data_index = r_data_cnt;
                    o_res.last_data  = (data_cnt_inc == r_len);
                end
                PH_WAIT_SUMH: begin
                    n_sum   = r_sum - {b, 8'd0};
                    n_phase = PH_WAIT_SUML;
                end
                PH_WAIT_SUML: begin
                    n_sum       = r_sum - {8'd0, b};
                    n_phase     = PH_WAIT_A;
                    o_res_valid = 1'b1;
                    o_res.result_kind = (n_sum == '0) ? atfp_pkg::RK_GOOD : atfp_pkg::RK_BAD;
                end
                default: begin
                    n_phase = PH_WAIT_A;
                end
            endcase
        end
        o_res.command_code = n_cmd;
        o_res.frame_length = n_len;
        o_res_valid        = o_res_valid & i_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT_A;
            r_sum      <= atfp_pkg::SUM_SEED_RST;
            r_len      <= '0;
            r_len_cnt  <= '0;
            r_data_cnt <= '0;
            r_cmd      <= '0;
            r_ticks    <= '0;
            r_sum_seed <= atfp_pkg::SUM_SEED_RST;
            r_timeout  <= atfp_pkg::TIMEOUT_RST;
        end else begin
            if (i_take) begin
                r_phase    <= n_phase;
                r_sum      <= n_sum;
                r_len      <= n_len;
                r_len_cnt  <= n_len_cnt;
                r_data_cnt <= n_data_cnt;
                r_cmd      <= n_cmd;
                r_ticks    <= n_ticks;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    atfp_pkg::CFG_SUM_SEED:      r_sum_seed <= i_cfg_data;
                    atfp_pkg::CFG_FRAME_TIMEOUT: r_timeout  <= i_cfg_data;
                    default:                     r_timeout  <= r_timeout;
                endcase
            end
        end
    end

    a_header_on_last_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.result_kind == atfp_pkg::RK_HEADER
            |-> r_phase == PH_WAIT_LEN && r_len_cnt == 2'd3)
        else $error("header result issued before the last length byte");

    a_data_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_WAIT_DATA |-> r_data_cnt < r_len)
        else $error("data count reached declared length inside the data phase");

    a_abandon_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.result_kind == atfp_pkg::RK_ABANDON |-> r_phase != PH_WAIT_A)
        else $error("abandon result issued while idle");

endmodule

// ----- rtl/atfp_out_stage.sv -----
// Result register with a skid entry for the AT frame parser output channel.
// Registers the upstream stall so the two channels are decoupled. Depends on atfp_pkg.
module atfp_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  atfp_pkg::t_out_item i_data,
    output logic                o_full,
    output logic                o_valid,
    output atfp_pkg::t_out_item o_data,
    input  logic                i_stall
);

    logic                r_out_valid;
    logic                r_skid_valid;
    atfp_pkg::t_out_item r_out;
    atfp_pkg::t_out_item r_skid;
    logic                drain;

    assign drain   = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (drain) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= i_push;
                end
            end else if (!r_out_valid) begin
                r_out_valid <= i_push;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (!r_out_valid) begin
            if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid)
        else $error("stalled result dropped");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_stall |=> r_out_valid && !r_skid_valid)
        else $error("skid entry not moved into output register");

endmodule

// ----- rtl/at_frame_parser_with_sum_check.sv -----
// Top level of the AT frame parser with 16-bit sum check.
// Instantiates atfp_core and atfp_out_stage; depends on atfp_pkg.
//
// Input channel: i_in_valid, o_in_stall, i_in_item carry bytes and millisecond ticks.
// A transfer takes place at a clock edge with valid high and stall low.
// Output channel: o_out_valid, i_out_stall, o_out_item carry header, data, good, bad
// and abandon results; items that produce no result produce no output transfer.
// Configuration: i_cfg_we with i_cfg_index and i_cfg_data writes the sum seed (index 0)
// or the frame timeout (index 1); write only while the block is idle.
// Throughput is one input item per cycle while o_in_stall is low; the parser state
// updates in the cycle an item is transferred, and its result is registered.
// The result register has a one-entry skid stage: o_in_stall rises only when the
// receiver stalls while both entries hold results, and drops once one drains.
// Reset (i_rst_n low at a clock edge) returns to waiting for 'A', empties the output
// and restores the register defaults (seed 0xAB34, timeout 225 ticks).
module at_frame_parser_with_sum_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  atfp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output atfp_pkg::t_out_item o_out_item
);

    logic                take;
    logic                res_valid;
    atfp_pkg::t_out_item res;
    logic                full;

    assign o_in_stall = full;
    assign take       = i_in_valid && !full;

    atfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_item      (i_in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    atfp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_data  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule

// ----- test/tb_top.sv -----
// Testbench for at_frame_parser_with_sum_check: a directed table, then random frame
// traffic over several register settings; every result transfer is checked field by field.
// Depends on atfp_pkg and the RTL top level at_frame_parser_with_sum_check.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 4;
    localparam int ABANDON_TICKS = 64;
    localparam int DIR_LEN       = 25;

    typedef enum logic [2:0] {
        ST_SYNC_A,
        ST_SYNC_T,
        ST_CMD,
        ST_LEN,
        ST_DATA,
        ST_SUM_HI,
        ST_SUM_LO
    } t_parse_state;

    typedef struct packed {
        logic                kind;
        logic [7:0]          byte_value;
        logic                typed;
        atfp_pkg::t_out_item want;
    } t_dir_row;

    localparam atfp_pkg::t_out_item NO_RESULT       = '0;
    localparam atfp_pkg::t_out_item WANT_HDR_EMPTY  =
        '{atfp_pkg::RK_HEADER, 8'hFF, 32'd0, 8'd0, 32'd0, 1'b0};
    localparam atfp_pkg::t_out_item WANT_GOOD_EMPTY =
        '{atfp_pkg::RK_GOOD, 8'hFF, 32'd0, 8'd0, 32'd0, 1'b0};
    localparam atfp_pkg::t_out_item WANT_HDR_ONE    =
        '{atfp_pkg::RK_HEADER, 8'h00, 32'd1, 8'd0, 32'd0, 1'b0};
    localparam atfp_pkg::t_out_item WANT_DATA_ONE   =
        '{atfp_pkg::RK_DATA, 8'h00, 32'd1, 8'hFF, 32'd0, 1'b1};
    localparam atfp_pkg::t_out_item WANT_BAD_ONE    =
        '{atfp_pkg::RK_BAD, 8'h00, 32'd1, 8'd0, 32'd0, 1'b0};

    // Reset register values throughout: seed 0xAB34, timeout 225 ticks.
    t_dir_row dir_table [DIR_LEN] = '{
        '{atfp_pkg::KIND_TICK, 8'hFF,            1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, atfp_pkg::CHAR_A, 1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'h58,            1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, atfp_pkg::CHAR_A, 1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, atfp_pkg::CHAR_A, 1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, atfp_pkg::CHAR_T, 1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, atfp_pkg::CHAR_A, 1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, atfp_pkg::CHAR_T, 1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'hFF,            1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'h00,            1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'h00,            1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'h00,            1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'h00,            1'b1, WANT_HDR_EMPTY},
        '{atfp_pkg::KIND_BYTE, 8'hAC,            1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'h33,            1'b1, WANT_GOOD_EMPTY},
        '{atfp_pkg::KIND_BYTE, atfp_pkg::CHAR_A, 1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, atfp_pkg::CHAR_T, 1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'h00,            1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'h00,            1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'h00,            1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'h00,            1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'h01,            1'b1, WANT_HDR_ONE},
        '{atfp_pkg::KIND_BYTE, 8'hFF,            1'b1, WANT_DATA_ONE},
        '{atfp_pkg::KIND_BYTE, 8'h00,            1'b0, NO_RESULT},
        '{atfp_pkg::KIND_BYTE, 8'h00,            1'b1, WANT_BAD_ONE}
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [15:0]         cfg_data;
    logic                in_valid;
    logic                in_stall;
    atfp_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_stall;
    atfp_pkg::t_out_item out_item;

    atfp_pkg::t_in_item  traffic_q[$];
    atfp_pkg::t_out_item pending_results[$];
    int          mismatches;
    int          cycle_count;
    int          stall_pct;
    int          holdoff_req;
    int          hold_left;

    logic [15:0]  seed_reg;
    logic [15:0]  timeout_reg;
    t_parse_state p_state;
    logic [15:0]  p_sum;
    logic [31:0]  p_len;
    logic [1:0]   p_len_bytes;
    logic [31:0]  p_count;
    logic [7:0]   p_cmd;
    logic [15:0]  p_ticks;

    at_frame_parser_with_sum_check uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic atfp_pkg::t_out_item frame_result(input atfp_pkg::t_result_kind kind);
        atfp_pkg::t_out_item r;
        r = '0;
        r.result_kind  = kind;
        r.command_code = p_cmd;
        r.frame_length = p_len;
        return r;
    endfunction

    function automatic bit deframe_step(input atfp_pkg::t_in_item it,
                                        output atfp_pkg::t_out_item res);
        logic [7:0] b;
        b   = it.byte_value;
        res = '0;
        if (it.kind == atfp_pkg::KIND_TICK) begin
            if (p_state == ST_SYNC_A) return 1'b0;
            if (p_ticks != atfp_pkg::TICKS_MAX) p_ticks = p_ticks + 16'd1;
            if (p_ticks >= timeout_reg) begin
                p_state = ST_SYNC_A;
                res = frame_result(atfp_pkg::RK_ABANDON);
                return 1'b1;
            end
            return 1'b0;
        end
        case (p_state)
            ST_SYNC_A: begin
                if (b == atfp_pkg::CHAR_A) begin
                    p_state = ST_SYNC_T;
                    p_ticks = '0;
                end
            end
            ST_SYNC_T: begin
                if (b == atfp_pkg::CHAR_T) begin
                    p_state = ST_CMD;
                    p_sum   = seed_reg;
                    p_len   = '0;
                    p_count = '0;
                    p_cmd   = '0;
                end else begin
                    p_state = ST_SYNC_A;
                end
            end
            ST_CMD: begin
                p_cmd       = b;
                p_sum       = p_sum + b;
                p_len_bytes = '0;
                p_state     = ST_LEN;
            end
            ST_LEN: begin
                p_sum = p_sum + b;
                p_len = {p_len[23:0], b};
                if (p_len_bytes == 2'd3) begin
                    p_len_bytes = '0;
                    p_state = (p_len != 32'd0) ? ST_DATA : ST_SUM_HI;
                    res = frame_result(atfp_pkg::RK_HEADER);
                    return 1'b1;
                end
                p_len_bytes = p_len_bytes + 2'd1;
            end
            ST_DATA: begin
                res = frame_result(atfp_pkg::RK_DATA);
                res.data_value = b;
                res.data_index = p_count;
                p_sum   = p_sum + b;
                p_count = p_count + 32'd1;
                res.last_data = (p_count == p_len);
                if (res.last_data) p_state = ST_SUM_HI;
                return 1'b1;
            end
            ST_SUM_HI: begin
                p_sum   = p_sum - {b, 8'h00};
                p_state = ST_SUM_LO;
            end
            ST_SUM_LO: begin
                p_sum   = p_sum - b;
                p_state = ST_SYNC_A;
                res = frame_result((p_sum == 16'd0) ? atfp_pkg::RK_GOOD : atfp_pkg::RK_BAD);
                return 1'b1;
            end
            default: begin
                p_state = ST_SYNC_A;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result_kind: expected no transfer, got 0x%0h", out_item.result_kind);
                mismatches++;
            end else begin
                atfp_pkg::t_out_item want;
                want = pending_results.pop_front();
                check_field("result_kind", want.result_kind, out_item.result_kind);
                check_field("command_code", want.command_code, out_item.command_code);
                check_field("frame_length", want.frame_length, out_item.frame_length);
                check_field("data_value", want.data_value, out_item.data_value);
                check_field("data_index", want.data_index, out_item.data_index);
                check_field("last_data", want.last_data, out_item.last_data);
            end
        end
    end

    initial begin
        out_stall = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (holdoff_req > 0) begin
                hold_left   = holdoff_req;
                holdoff_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic offer_item(input atfp_pkg::t_in_item it, input int gap, input bit typed,
                              input atfp_pkg::t_out_item want);
        atfp_pkg::t_out_item res;
        bit                  has;
        while ($urandom_range(99) < gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        has = deframe_step(it, res);
        if (typed) pending_results.push_back(want);
        else if (has) pending_results.push_back(res);
    endtask

    task automatic go_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input atfp_pkg::t_cfg_index idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == atfp_pkg::CFG_SUM_SEED) seed_reg = value;
        else timeout_reg = value;
    endtask

    task automatic push_tick();
        atfp_pkg::t_in_item it;
        it.kind       = atfp_pkg::KIND_TICK;
        it.byte_value = 8'($urandom());
        traffic_q.push_back(it);
    endtask

    task automatic push_byte(input logic [7:0] b);
        atfp_pkg::t_in_item it;
        if ($urandom_range(99) < 3) push_tick();
        it.kind       = atfp_pkg::KIND_BYTE;
        it.byte_value = b;
        traffic_q.push_back(it);
    endtask

    task automatic plan_burst();
        int          tmo_eff;
        int          pick;
        int          k;
        logic [7:0]  cmd;
        logic [7:0]  b;
        logic [31:0] len;
        logic [15:0] sum;
        tmo_eff = (timeout_reg == 16'd0) ? 1 : int'(timeout_reg);
        if (p_state == ST_DATA && (p_len - p_count) > ABANDON_TICKS
                && tmo_eff <= ABANDON_TICKS) begin
            repeat (ABANDON_TICKS) push_tick();
            return;
        end
        pick = $urandom_range(99);
        if (pick < 80) begin
            cmd  = 8'($urandom());
            pick = $urandom_range(99);
            if (pick < 60) len = $urandom_range(6, 0);
            else if (pick < 90 || tmo_eff > ABANDON_TICKS) len = $urandom_range(40, 7);
            else len = {8'($urandom_range(255, 1)), 24'($urandom())};
            sum = seed_reg + cmd + len[31:24] + len[23:16] + len[15:8] + len[7:0];
            push_byte(atfp_pkg::CHAR_A);
            push_byte(atfp_pkg::CHAR_T);
            push_byte(cmd);
            for (k = 3; k >= 0; k--) push_byte(len[8*k +: 8]);
            if (len > ABANDON_TICKS) begin
                repeat ($urandom_range(20, 1)) push_byte(8'($urandom()));
                repeat (ABANDON_TICKS) push_tick();
                return;
            end
            repeat (len) begin
                b   = 8'($urandom());
                sum = sum + b;
                push_byte(b);
            end
            if ($urandom_range(99) < 20) sum = sum ^ (16'd1 << $urandom_range(15, 0));
            push_byte(sum[15:8]);
            push_byte(sum[7:0]);
        end else if (pick < 90) begin
            push_byte(atfp_pkg::CHAR_A);
            b = ($urandom_range(2, 0) == 0) ? atfp_pkg::CHAR_A : 8'($urandom());
            if (b == atfp_pkg::CHAR_T) b = 8'h00;
            push_byte(b);
        end else if (pick < 95) begin
            repeat ($urandom_range(4, 1)) begin
                b = 8'($urandom());
                if (b == atfp_pkg::CHAR_T) b = ~b;
                push_byte(b);
            end
        end else begin
            repeat ($urandom_range(3, 1)) push_tick();
        end
    endtask

    task automatic run_phase(input logic [15:0] seed, input logic [15:0] tmo, input int gap,
                             input int stall, input int n_items, input int holdoff,
                             input bit keep_tail);
        atfp_pkg::t_in_item it;
        int                 sent;
        drain();
        write_cfg(atfp_pkg::CFG_SUM_SEED, seed);
        write_cfg(atfp_pkg::CFG_FRAME_TIMEOUT, tmo);
        stall_pct = stall;
        if (holdoff > 0) holdoff_req = holdoff;
        sent = 0;
        while (sent < n_items || (!keep_tail && traffic_q.size() != 0)) begin
            if (traffic_q.size() == 0) plan_burst();
            it = traffic_q.pop_front();
            offer_item(it, gap, 1'b0, NO_RESULT);
            sent++;
        end
        go_quiet();
    endtask

    initial begin
        atfp_pkg::t_in_item it;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = atfp_pkg::CFG_SUM_SEED;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_item     = '0;
        mismatches  = 0;
        stall_pct   = 0;
        holdoff_req = 0;
        seed_reg    = atfp_pkg::SUM_SEED_RST;
        timeout_reg = atfp_pkg::TIMEOUT_RST;
        p_state     = ST_SYNC_A;
        p_sum       = atfp_pkg::SUM_SEED_RST;
        p_len       = '0;
        p_len_bytes = '0;
        p_count     = '0;
        p_cmd       = '0;
        p_ticks     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_LEN; i++) begin
            it.kind       = dir_table[i].kind;
            it.byte_value = dir_table[i].byte_value;
            offer_item(it, 0, dir_table[i].typed, dir_table[i].want);
        end
        go_quiet();

        run_phase(16'hFFFF, 16'hFFFF, 0, 0, 350, 0, 1'b0);
        run_phase(16'h0000, 16'd1, 81, 0, 300, 0, 1'b0);
        run_phase(16'($urandom()), 16'd0, 0, 81, 300, 0, 1'b1);
        run_phase(16'($urandom()), 16'($urandom_range(64, 2)), 30, 30, 350, 0, 1'b0);
        run_phase(16'($urandom()), 16'($urandom_range(64, 2)), 0, 0, 300, 300, 1'b0);
        run_phase(16'($urandom()), 16'd1000, 30, 30, 300, 0, 1'b0);

        stall_pct = 0;
        drain();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
